[rtl/checked_integer_alu_defines.svh]
// assertion macros for the checked integer alu
`ifndef CHECKED_INTEGER_ALU_DEFINES_SVH
`define CHECKED_INTEGER_ALU_DEFINES_SVH
`ifndef SYNTH
`define CIA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define CIA_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define CIA_ASSERT(label, clk, rst, prop)
`define CIA_ASSERT_RST(label, clk, prop)
`endif
`endif

[rtl/cia_pkg.sv]
// shared opcode type for the checked integer alu
package cia_pkg;
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;
endpackage

[rtl/cia_req_if.sv]
// request channel: opcode and two operands
interface cia_req_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic signed [DATA_WIDTH-1:0] operand_a;
  logic signed [DATA_WIDTH-1:0] operand_b;
  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink (input valid, req_type, operand_a, operand_b, output ready);
endinterface

[rtl/cia_rsp_if.sv]
// response channel: result and error flag
interface cia_rsp_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] result_value;
  logic                         error_flag;
  modport source (output valid, result_value, error_flag, input ready);
  modport sink (input valid, result_value, error_flag, output ready);
endinterface

[rtl/cia_div.sv]
// pipelined restoring divider on magnitudes, one quotient bit per stage
module cia_div #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output logic [DATA_WIDTH-1:0] quotient
);
  localparam int W = DATA_WIDTH;

  logic [W-1:0] rem [W+1];
  logic [W-1:0] quo [W+1];
  logic [W-1:0] dvs [W+1];

  assign rem[0] = '0;
  assign quo[0] = dividend;
  assign dvs[0] = divisor;

  // one quotient bit per stage
  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W:0] shifted;
    logic [W:0] diff;
    assign shifted = {rem[i], quo[i][W-1]};
    assign diff    = shifted - {1'b0, dvs[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[W]) begin
          rem[i+1] <= diff[W-1:0];
        end else begin
          rem[i+1] <= shifted[W-1:0];
        end
        quo[i+1] <= {quo[i][W-2:0], ~diff[W]};
        dvs[i+1] <= dvs[i];
      end
    end
  end

  assign quotient = quo[W];
endmodule

[rtl/checked_integer_alu.sv]
// top level of the overflow-checked signed integer alu
// channel | dir | payload
// req     | in  | req_type, operand_a, operand_b
// rsp     | out | result_value, error_flag
// a result passes through the stage 1 registers, the divider's bit-per-stage chain and the output register
// one beat enters every cycle while rsp is not stalled; all stages advance together when the output can move
// a stall on rsp freezes the whole pipeline, nothing is lost or repeated
// rst clears valid bits and holds req.ready low; the data registers are not reset
module checked_integer_alu #(
  parameter int DATA_WIDTH = 32
) (
  input logic clk,
  input logic rst,
  cia_req_if.sink   req,
  cia_rsp_if.source rsp
);
  `include "checked_integer_alu_defines.svh"
  localparam int W = DATA_WIDTH;
  localparam int D = W + 2;

  logic en;
  logic [D-1:0] vld;
  assign en = !rsp.valid || rsp.ready;
  assign req.ready = en && !rst;

  // stage 1: decode, magnitudes, add/sub, and add/sub/div error checks
  logic [1:0]   op1;
  logic         neg1;
  logic [W-1:0] ma1, mb1, sum1;
  logic         err1;
  logic [W-1:0] a_in, b_in, ma_in, mb_in, add_r, sub_r;
  assign a_in  = req.operand_a;
  assign b_in  = req.operand_b;
  assign ma_in = a_in[W-1] ? (~a_in + 1'b1) : a_in;
  assign mb_in = b_in[W-1] ? (~b_in + 1'b1) : b_in;
  assign add_r = a_in + b_in;
  assign sub_r = a_in - b_in;

  always_ff @(posedge clk) begin
    if (en) begin
      op1  <= req.req_type;
      neg1 <= a_in[W-1] ^ b_in[W-1];
      ma1  <= ma_in;
      mb1  <= mb_in;
      case (cia_pkg::op_t'(req.req_type))
        cia_pkg::OP_ADD: begin
          sum1 <= add_r;
          err1 <= (a_in[W-1] == b_in[W-1]) && (add_r[W-1] != a_in[W-1]);
        end
        cia_pkg::OP_SUB: begin
          sum1 <= sub_r;
          err1 <= (a_in[W-1] != b_in[W-1]) && (sub_r[W-1] != a_in[W-1]);
        end
        cia_pkg::OP_DIV: begin
          sum1 <= '0;
          err1 <= (b_in == '0) ||
                  (a_in == {1'b1, {(W-1){1'b0}}} && b_in == '1);
        end
        default: begin
          sum1 <= '0;
          err1 <= 1'b0;
        end
      endcase
    end
  end

  // stage 2: magnitude product
  logic [2*W-1:0] prod2;
  always_ff @(posedge clk) begin
    if (en) begin
      prod2 <= ma1 * mb1;
    end
  end

  // stage 3: product range check and signing
  logic [W-1:0] mulr3;
  logic         mulerr3;
  logic [2*W-1:0] lim2;
  logic         neg2;
  always_ff @(posedge clk) begin
    if (en) begin
      neg2 <= neg1;
    end
  end
  assign lim2 = neg2 ? (2*W)'({1'b1, {(W-1){1'b0}}}) : (2*W)'({1'b0, {(W-1){1'b1}}});
  always_ff @(posedge clk) begin
    if (en) begin
      mulerr3 <= prod2 > lim2;
      mulr3   <= neg2 ? (~prod2[W-1:0] + 1'b1) : prod2[W-1:0];
    end
  end

  // side data delayed alongside the divider
  logic [W-1:0] quo;
  cia_div #(.DATA_WIDTH(W)) u_div (
    .clk(clk), .en(en), .dividend(ma1), .divisor(mb1), .quotient(quo)
  );

  logic [1:0]   opd [W+1];
  logic         ngd [W+1];
  logic         erd [W+1];
  logic [W-1:0] rsd [W+1];
  assign opd[0] = op1;
  assign ngd[0] = neg1;
  assign erd[0] = err1;
  assign rsd[0] = sum1;
  for (genvar i = 0; i < W; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        opd[i+1] <= opd[i];
        ngd[i+1] <= ngd[i];
        erd[i+1] <= erd[i];
        rsd[i+1] <= (i == 2) ? ((opd[2] == 2'(cia_pkg::OP_MUL)) ? mulr3 : rsd[i]) : rsd[i];
      end
    end
  end
  // carry the multiplier error in its own delay line and OR it with the delayed error at the final stage
  logic [W-3:0] mul_err_d;
  always_ff @(posedge clk) begin
    if (en) begin
      mul_err_d <= {mul_err_d[W-4:0], mulerr3 && (opd[2] == 2'(cia_pkg::OP_MUL))};
    end
  end

  // final stage: select and zero on error
  logic         err_f;
  logic [W-1:0] res_f;
  assign err_f = erd[W] || mul_err_d[W-3];
  always_comb begin
    if (opd[W] == 2'(cia_pkg::OP_DIV)) begin
      res_f = ngd[W] ? (~quo + 1'b1) : quo;
    end else begin
      res_f = rsd[W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[D-2:0], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.result_value <= err_f ? '0 : res_f;
      rsp.error_flag   <= err_f;
    end
  end
  assign rsp.valid = vld[D-1];

  `CIA_ASSERT(a_zero_on_err, clk, rst, rsp.valid && rsp.error_flag |-> rsp.result_value == '0)
  `CIA_ASSERT(a_stall_holds, clk, rst, rsp.valid && !rsp.ready |=> rsp.valid)
  `CIA_ASSERT(a_ready_free, clk, rst, !rsp.valid |-> req.ready)
  `CIA_ASSERT_RST(a_rst_clears, clk, rst |=> !rsp.valid)
endmodule
